/* hdl/ofb_pkg.sv */
// Shared types, constants and helpers for the overwrite FIFO with burst read.
`timescale 1ns / 1ps
package ofb_pkg;

	localparam int unsigned DEPTH      = 64;
	localparam int unsigned SAMPLE_W   = 64;
	localparam int unsigned IDX_W      = $clog2(DEPTH);
	localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
	localparam int unsigned OVR_W      = 32;
	localparam int unsigned MIN_CAP    = 2;

	localparam int unsigned CFG_ADDR_W = 1;
	localparam int unsigned CFG_DATA_W = 7;

	// Input tdata: sample_in, read_count; padded to whole bytes.
	localparam int unsigned IN_USED_W   = SAMPLE_W + CNT_W;
	localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// Output tdata: sample_out, accepted, fill_level, is_empty, overrun_total.
	localparam int unsigned OUT_ACC_LSB   = SAMPLE_W;
	localparam int unsigned OUT_FILL_LSB  = OUT_ACC_LSB + 1;
	localparam int unsigned OUT_EMPTY_LSB = OUT_FILL_LSB + CNT_W;
	localparam int unsigned OUT_OVR_LSB   = OUT_EMPTY_LSB + 1;
	localparam int unsigned OUT_USED_W    = OUT_OVR_LSB + OVR_W;
	localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY    = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_DROP_OLDEST = 1'b1;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [OVR_W-1:0]    ovr_t;

	// Per-cycle command to the cell chain.
	typedef struct packed {
		logic shift;
		logic load;
		idx_t load_idx;
	} chain_ctl_t;

	// Clamp the programmed capacity to MIN_CAP..DEPTH.
	function automatic cnt_t sat_cap(input logic [CFG_DATA_W-1:0] c);
		cnt_t r;
		r = CNT_W'(c);
		if (c < CFG_DATA_W'(MIN_CAP)) begin
			r = CNT_W'(MIN_CAP);
		end else if (c > CFG_DATA_W'(DEPTH)) begin
			r = CNT_W'(DEPTH);
		end
		return r;
	endfunction

endpackage

/* hdl/ofb_cell.sv */
// One storage cell of the chain: loads a new sample or takes its upper neighbor's word.
`timescale 1ns / 1ps
module ofb_cell (
	input  logic             clk,
	input  logic             shift,
	input  logic             load_sel,
	input  ofb_pkg::sample_t sample,
	input  ofb_pkg::sample_t nbr,
	output ofb_pkg::sample_t data
);
	import ofb_pkg::*;

	sample_t data_q;

	always_ff @(posedge clk) begin
		if (load_sel) begin
			data_q <= sample;
		end else if (shift) begin
			data_q <= nbr;
		end
	end

	assign data = data_q;

endmodule

/* hdl/ofb_chain.sv */
// Row of storage cells, oldest sample at cell zero, shifting toward the head.
`timescale 1ns / 1ps
module ofb_chain (
	input  logic               clk,
	input  ofb_pkg::chain_ctl_t ctl,
	input  ofb_pkg::sample_t   sample,
	output ofb_pkg::sample_t   head
);
	import ofb_pkg::*;

	sample_t cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sample_t nbr;
		logic    load_sel;

		if (i == DEPTH - 1) begin : g_top
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end

		assign load_sel = ctl.load && (ctl.load_idx == IDX_W'(i));

		ofb_cell u_cell (
			.clk      (clk),
			.shift    (ctl.shift),
			.load_sel (load_sel),
			.sample   (sample),
			.nbr      (nbr),
			.data     (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

/* hdl/overwrite_fifo_with_burst_read.sv */
// Sample FIFO with drop-oldest overwrite and burst read (top level).
//
// Input beats (s_*): s_tuser is the mode, 0 writes one sample, 1 reads a burst.
// Each write gives one output beat with tlast set and the write outcome.
// A read of N samples gives min(N, fill level) beats, oldest first, tlast on
// the final one; an empty or zero-length read gives a single status beat.
// Every output beat carries fill level, empty flag and the overrun total.
// Samples live in a chain of 64 cells; a read takes cell zero and shifts the
// chain down by one, a write loads the cell at the fill level.
// The first output beat is registered in the cycle after the input beat is taken.
// A read delivers its samples by one cell shift per sample, each feeding the
// output register, one per cycle while the output is not stalled. No new
// input beat is taken until the last beat of a burst has been produced.
// The output register is free to refill in the cycle it is drained, so the
// block runs at one beat per cycle while m_tready stays high; a stall holds
// the output beat and the input side.
// Reset clears the fill level, burst counter and overrun counter, sets capacity to
// 64 and drop-oldest off. Writing capacity empties the FIFO and clears the
// overrun counter; cfg_ready is high only while no burst runs, no output beat
// waits and no input beat is offered.
`timescale 1ns / 1ps
module overwrite_fifo_with_burst_read (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ofb_pkg::IN_TDATA_W-1:0]        s_tdata,  // sample_in, read_count
	input  logic                                  s_tuser,  // mode
	// master side
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// sample_out, accepted, fill_level, is_empty, overrun_total
	output logic [ofb_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                  m_tuser,  // has_sample
	output logic                                  m_tlast,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ofb_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [ofb_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import ofb_pkg::*;

	typedef enum logic {ST_IDLE, ST_BURST} state_t;

	state_t                state_q;
	logic [CFG_DATA_W-1:0] capacity_q;
	logic                  drop_oldest_q;
	cnt_t                  count_q;
	cnt_t                  remain_q;
	ovr_t                  ovr_q;

	logic    m_valid_q;
	sample_t sample_out_q;
	logic    has_sample_q;
	logic    last_q;
	logic    accepted_q;
	cnt_t    fill_q;
	logic    empty_q;

	sample_t    head;
	chain_ctl_t ctl;
	sample_t    sample_in;
	cnt_t       read_count;
	cnt_t       cap_eff;
	cnt_t       burst_n;
	logic       out_free;
	logic       in_take;
	logic       burst_take;
	logic       cfg_take;

	assign sample_in  = s_tdata[SAMPLE_W-1:0];
	assign read_count = s_tdata[SAMPLE_W +: CNT_W];
	assign cap_eff    = sat_cap(capacity_q);
	assign burst_n    = (read_count < count_q) ? read_count : count_q;

	assign out_free   = !m_valid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE) && out_free;
	assign in_take    = s_tvalid && s_tready;
	assign burst_take = (state_q == ST_BURST) && out_free;
	// take configuration only when nothing is in flight
	assign cfg_ready  = (state_q == ST_IDLE) && !m_valid_q && !s_tvalid;
	assign cfg_take   = cfg_valid && cfg_ready;

	// Chain command for this cycle.
	always_comb begin
		ctl = '0;
		if (in_take && !s_tuser) begin
			if (count_q < cap_eff) begin
				ctl.load     = 1'b1;
				ctl.load_idx = count_q[IDX_W-1:0];
			end else if (drop_oldest_q) begin
				ctl.shift    = 1'b1;
				ctl.load     = 1'b1;
				ctl.load_idx = IDX_W'(cap_eff - CNT_W'(1));
			end
		end else if (in_take && s_tuser) begin
			ctl.shift = (burst_n != '0);
		end else if (burst_take) begin
			ctl.shift = 1'b1;
		end
	end

	ofb_chain u_chain (
		.clk    (clk),
		.ctl    (ctl),
		.sample (sample_in),
		.head   (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			capacity_q    <= CFG_DATA_W'(DEPTH);
			drop_oldest_q <= 1'b0;
			count_q       <= '0;
			remain_q      <= '0;
			ovr_q         <= '0;
			m_valid_q     <= 1'b0;
			sample_out_q  <= '0;
			has_sample_q  <= 1'b0;
			last_q        <= 1'b0;
			accepted_q    <= 1'b0;
			fill_q        <= '0;
			empty_q       <= 1'b1;
		end else begin
			if (in_take && !s_tuser) begin
				m_valid_q    <= 1'b1;
				sample_out_q <= '0;
				has_sample_q <= 1'b0;
				last_q       <= 1'b1;
				if (count_q < cap_eff) begin
					count_q    <= count_q + CNT_W'(1);
					accepted_q <= 1'b1;
					fill_q     <= count_q + CNT_W'(1);
					empty_q    <= 1'b0;
					ovr_q      <= ovr_q;
				end else begin
					// full: overwrite oldest or reject, count either way
					accepted_q <= drop_oldest_q;
					fill_q     <= count_q;
					empty_q    <= (count_q == '0);
					ovr_q      <= ovr_q + OVR_W'(1);
				end
			end else if (in_take && s_tuser) begin
				m_valid_q  <= 1'b1;
				accepted_q <= 1'b0;
				if (burst_n == '0) begin
					sample_out_q <= '0;
					has_sample_q <= 1'b0;
					last_q       <= 1'b1;
					fill_q       <= count_q;
					empty_q      <= (count_q == '0);
				end else begin
					sample_out_q <= head;
					has_sample_q <= 1'b1;
					last_q       <= (burst_n == CNT_W'(1));
					count_q      <= count_q - CNT_W'(1);
					fill_q       <= count_q - CNT_W'(1);
					empty_q      <= (count_q == CNT_W'(1));
					remain_q     <= burst_n - CNT_W'(1);
					if (burst_n != CNT_W'(1)) begin
						state_q <= ST_BURST;
					end
				end
			end else if (burst_take) begin
				m_valid_q    <= 1'b1;
				accepted_q   <= 1'b0;
				sample_out_q <= head;
				has_sample_q <= 1'b1;
				last_q       <= (remain_q == CNT_W'(1));
				count_q      <= count_q - CNT_W'(1);
				fill_q       <= count_q - CNT_W'(1);
				empty_q      <= (count_q == CNT_W'(1));
				remain_q     <= remain_q - CNT_W'(1);
				if (remain_q == CNT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			if (cfg_take) begin
				case (cfg_addr)
					REG_CAPACITY: begin
						capacity_q <= cfg_data;
						count_q    <= '0;
						ovr_q      <= '0;
					end
					REG_DROP_OLDEST: begin
						drop_oldest_q <= cfg_data[0];
					end
					default: begin
						drop_oldest_q <= drop_oldest_q;
					end
				endcase
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = has_sample_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, ovr_q, empty_q, fill_q, accepted_q, sample_out_q};

endmodule

/* hdl/ofb_checker.sv */
// Port-level checks for the overwrite FIFO, bound to the top level.
`timescale 1ns / 1ps
module ofb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [ofb_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input logic                                m_tuser,
	input logic                                m_tlast
);
	import ofb_pkg::*;

	// Hold a stalled output beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Empty flag agrees with the fill level.
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_EMPTY_LSB] == (m_tdata[OUT_FILL_LSB +: CNT_W] == '0)))
		else $error("is_empty disagrees with fill_level");

	// A beat without a sample closes its item; a sample beat is never a write outcome.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("status beat without tlast");

	a_sample_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[OUT_ACC_LSB])
		else $error("read sample flagged as accepted write");

	// Drop input ready while a burst is still in progress.
	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken in the middle of a burst");

endmodule

bind overwrite_fifo_with_burst_read ofb_checker u_ofb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* dv/tb_top.sv */
// Self-checking testbench for the overwrite FIFO with burst read.
`timescale 1ns / 1ps
module tb_top;
	import ofb_pkg::*;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_READ   = 1'b1;
	localparam int   MAX_BURST   = 64;
	localparam int   CYCLE_LIMIT = 600000;

	typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_CFG} row_kind_e;

	typedef struct packed {
		sample_t sample;
		logic    has;
		logic    last;
		logic    acc;
		cnt_t    fill;
		logic    empty;
		ovr_t    ovr;
	} beat_t;

	typedef struct packed {
		row_kind_e               kind;
		logic [CFG_ADDR_W-1:0]   addr;
		sample_t                 val;
		cnt_t                    count;
		logic                    typed;
		beat_t                   want;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_TDATA_W-1:0]    s_tdata;   // sample_in, read_count
	logic                     s_tuser;   // mode
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_tdata;   // sample_out, accepted, fill_level, is_empty, overrun_total
	logic                     m_tuser;   // has_sample
	logic                     m_tlast;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_ADDR_W-1:0]    cfg_addr;
	logic [CFG_DATA_W-1:0]    cfg_data;

	// Mirror of the FIFO state
	sample_t                  mirror_mem [DEPTH];
	int unsigned              mirror_wr;
	int unsigned              mirror_rd;
	int unsigned              mirror_level;
	ovr_t                     mirror_overruns;
	logic [CFG_DATA_W-1:0]    mirror_cap;
	logic                     mirror_drop;

	beat_t                    step_beats [$];
	beat_t                    pending_beats [$];
	plan_row_t                directed [$];

	int unsigned              cycle_count;
	int unsigned              mismatches;
	int unsigned              burst_left;
	int unsigned              writes_sent;
	int unsigned              reads_sent;
	int unsigned              beats_checked;
	int unsigned              full_writes;
	int unsigned              cap_settings;
	int unsigned              longest_burst;
	int unsigned              stall_style;
	int unsigned              stall_hold = 0;
	int unsigned              stall_tick = 0;
	beat_t                    seen_beat;
	beat_t                    due_beat;

	overwrite_fifo_with_burst_read dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic beat_t fifo_beat(input sample_t smp, input logic has, input logic last,
		input logic acc);
		beat_t b;
		b.sample = smp;
		b.has    = has;
		b.last   = last;
		b.acc    = acc;
		b.fill   = cnt_t'(mirror_level);
		b.empty  = (mirror_level == 0);
		b.ovr    = mirror_overruns;
		return b;
	endfunction

	function automatic beat_t status_only(input logic acc, input int fill, input int ovr);
		beat_t b;
		b.sample = '0;
		b.has    = 1'b0;
		b.last   = 1'b1;
		b.acc    = acc;
		b.fill   = cnt_t'(fill);
		b.empty  = (fill == 0);
		b.ovr    = ovr_t'(ovr);
		return b;
	endfunction

	function automatic plan_row_t mk_row(input row_kind_e kind, input sample_t val, input int cnt,
		input logic typed, input beat_t want);
		plan_row_t r;
		r.kind  = kind;
		r.addr  = (kind == ROW_CFG) ? CFG_ADDR_W'(cnt) : '0;
		r.val   = val;
		r.count = cnt_t'(cnt);
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	// Advance the mirror by one input beat and leave its output beats in step_beats.
	function automatic void predict_fifo_beats(input logic mode, input sample_t smp,
		input cnt_t want_cnt);
		int unsigned cap;
		int unsigned n;
		logic        acc;
		cap = mirror_cap;
		if (cap < MIN_CAP) begin
			cap = MIN_CAP;
		end else if (cap > DEPTH) begin
			cap = DEPTH;
		end
		step_beats.delete();
		if (mode == MODE_WRITE) begin
			acc = 1'b1;
			if (mirror_level < cap) begin
				mirror_mem[mirror_wr] = smp;
				mirror_wr = (mirror_wr + 1 >= cap) ? 0 : mirror_wr + 1;
				mirror_level++;
			end else if (mirror_drop) begin
				// overwrite the oldest entry and push the read side along
				mirror_mem[mirror_wr] = smp;
				mirror_wr = (mirror_wr + 1 >= cap) ? 0 : mirror_wr + 1;
				mirror_rd = (mirror_rd + 1 >= cap) ? 0 : mirror_rd + 1;
				mirror_overruns++;
			end else begin
				mirror_overruns++;
				acc = 1'b0;
			end
			step_beats.push_back(fifo_beat('0, 1'b0, 1'b1, acc));
		end else begin
			n = want_cnt;
			if (n > mirror_level) n = mirror_level;
			if (n > MAX_BURST) n = MAX_BURST;
			if (n == 0) begin
				step_beats.push_back(fifo_beat('0, 1'b0, 1'b1, 1'b0));
			end
			for (int k = 0; k < n; k++) begin
				smp = mirror_mem[mirror_rd];
				mirror_rd = (mirror_rd + 1 >= cap) ? 0 : mirror_rd + 1;
				mirror_level--;
				step_beats.push_back(fifo_beat(smp, 1'b1, (k + 1 == n), 1'b0));
			end
		end
	endfunction

	// Hold the sender until every expected beat has come back.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_addr  = addr;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (addr == REG_CAPACITY) begin
			mirror_cap      = data;
			mirror_wr       = 0;
			mirror_rd       = 0;
			mirror_level    = 0;
			mirror_overruns = '0;
			cap_settings++;
		end else if (addr == REG_DROP_OLDEST) begin
			mirror_drop = data[0];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_item(input logic mode, input sample_t smp, input cnt_t want_cnt,
		input logic typed, input beat_t typed_beat);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {{(IN_TDATA_W - IN_USED_W){1'b0}}, want_cnt, smp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mode == MODE_WRITE) begin
			writes_sent++;
			if (mirror_level >= ((mirror_cap < MIN_CAP) ? MIN_CAP :
				(mirror_cap > DEPTH) ? DEPTH : mirror_cap)) full_writes++;
		end else begin
			reads_sent++;
		end
		predict_fifo_beats(mode, smp, want_cnt);
		if (step_beats.size() > longest_burst) longest_burst = step_beats.size();
		if (typed) begin
			pending_beats.push_back(typed_beat);
		end else begin
			foreach (step_beats[j]) pending_beats.push_back(step_beats[j]);
		end
		burst_left--;
	endtask

	task automatic flag_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
	endtask

	// Receiver: switch between always-ready, random and periodic stalls.
	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_style = $urandom_range(0, 2);
			stall_hold  = $urandom_range(20, 120);
		end
		stall_hold--;
		stall_tick++;
		case (stall_style)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 2) != 0);
			default: m_tready <= (stall_tick % 4 != 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_beat.sample = m_tdata[SAMPLE_W-1:0];
			seen_beat.has    = m_tuser;
			seen_beat.last   = m_tlast;
			seen_beat.acc    = m_tdata[OUT_ACC_LSB];
			seen_beat.fill   = m_tdata[OUT_FILL_LSB +: CNT_W];
			seen_beat.empty  = m_tdata[OUT_EMPTY_LSB];
			seen_beat.ovr    = m_tdata[OUT_OVR_LSB +: OVR_W];
			if (pending_beats.size() == 0) begin
				mismatches++;
				$display("%0t ns: output beat with none expected, got %h", $time, seen_beat);
			end else begin
				due_beat = pending_beats.pop_front();
				beats_checked++;
				if (seen_beat.sample !== due_beat.sample)
					flag_field("sample_out", due_beat.sample, seen_beat.sample);
				if (seen_beat.has !== due_beat.has)
					flag_field("has_sample", 64'(due_beat.has), 64'(seen_beat.has));
				if (seen_beat.last !== due_beat.last)
					flag_field("last", 64'(due_beat.last), 64'(seen_beat.last));
				if (seen_beat.acc !== due_beat.acc)
					flag_field("accepted", 64'(due_beat.acc), 64'(seen_beat.acc));
				if (seen_beat.fill !== due_beat.fill)
					flag_field("fill_level", 64'(due_beat.fill), 64'(seen_beat.fill));
				if (seen_beat.empty !== due_beat.empty)
					flag_field("is_empty", 64'(due_beat.empty), 64'(seen_beat.empty));
				if (seen_beat.ovr !== due_beat.ovr)
					flag_field("overrun_total", 64'(due_beat.ovr), 64'(seen_beat.ovr));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t ns: cycle limit hit, %0d beats outstanding", $time, pending_beats.size());
		$display("Regression FAIL");
		$finish;
	end

	logic                  ph_mode;
	int unsigned           ph_items;
	int unsigned           ph_wr_pct;
	logic [CFG_DATA_W-1:0] ph_cap;
	logic                  ph_drop;
	cnt_t                  ph_cnt;
	int unsigned           pick;

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = MODE_WRITE;
		cfg_valid       = 1'b0;
		cfg_addr        = '0;
		cfg_data        = '0;
		mirror_wr       = 0;
		mirror_rd       = 0;
		mirror_level    = 0;
		mirror_overruns = '0;
		mirror_cap      = 7'd64;
		mirror_drop     = 1'b0;
		mismatches      = 0;
		burst_left      = 0;
		writes_sent     = 0;
		reads_sent      = 0;
		beats_checked   = 0;
		full_writes     = 0;
		cap_settings    = 0;
		longest_burst   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: reset state, empty reads, full reject, overwrite, saturated capacity.
		directed.push_back(mk_row(ROW_READ, '0, 0, 1'b1, status_only(1'b0, 0, 0)));
		directed.push_back(mk_row(ROW_READ, '0, 64, 1'b1, status_only(1'b0, 0, 0)));
		directed.push_back(mk_row(ROW_WRITE, '1, 0, 1'b1, status_only(1'b1, 1, 0)));
		directed.push_back(mk_row(ROW_READ, '0, 64, 1'b0, '0));
		directed.push_back(mk_row(ROW_CFG, 64'd2, REG_CAPACITY, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, '0, 64, 1'b1, status_only(1'b1, 1, 0)));
		directed.push_back(mk_row(ROW_WRITE, 64'h8000_0000_0000_0001, 0, 1'b1,
			status_only(1'b1, 2, 0)));
		directed.push_back(mk_row(ROW_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 0, 1'b1,
			status_only(1'b0, 2, 1)));
		directed.push_back(mk_row(ROW_READ, '1, 0, 1'b1, status_only(1'b0, 2, 1)));
		directed.push_back(mk_row(ROW_READ, '0, 1, 1'b0, '0));
		directed.push_back(mk_row(ROW_CFG, 64'd1, REG_DROP_OLDEST, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, '1, 0, 1'b1, status_only(1'b1, 2, 1)));
		directed.push_back(mk_row(ROW_WRITE, 64'h0123_4567_89AB_CDEF, 0, 1'b1,
			status_only(1'b1, 2, 2)));
		directed.push_back(mk_row(ROW_WRITE, 64'h5555_5555_5555_5555, 0, 1'b1,
			status_only(1'b1, 2, 3)));
		directed.push_back(mk_row(ROW_READ, '0, 64, 1'b0, '0));
		directed.push_back(mk_row(ROW_CFG, 64'd0, REG_CAPACITY, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, 64'd1, 0, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, 64'd2, 0, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, 64'd3, 0, 1'b0, '0));
		directed.push_back(mk_row(ROW_READ, '0, 3, 1'b0, '0));
		directed.push_back(mk_row(ROW_CFG, 64'd127, REG_CAPACITY, 1'b0, '0));
		directed.push_back(mk_row(ROW_CFG, 64'h7E, REG_DROP_OLDEST, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, 64'hDEAD_BEEF_0BAD_F00D, 0, 1'b1,
			status_only(1'b1, 1, 0)));
		directed.push_back(mk_row(ROW_READ, '0, 64, 1'b0, '0));
		directed.push_back(mk_row(ROW_CFG, 64'd1, REG_CAPACITY, 1'b0, '0));
		directed.push_back(mk_row(ROW_WRITE, 64'h00FF_00FF_00FF_00FF, 0, 1'b1,
			status_only(1'b1, 1, 0)));
		directed.push_back(mk_row(ROW_WRITE, 64'hFF00_FF00_FF00_FF00, 0, 1'b1,
			status_only(1'b1, 2, 0)));
		directed.push_back(mk_row(ROW_WRITE, 64'hFFFF_0000_FFFF_0000, 0, 1'b1,
			status_only(1'b0, 2, 1)));
		directed.push_back(mk_row(ROW_READ, '0, 2, 1'b0, '0));

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				write_reg(directed[i].addr, directed[i].val[CFG_DATA_W-1:0]);
			end else begin
				send_item((directed[i].kind == ROW_READ) ? MODE_READ : MODE_WRITE,
					directed[i].val, directed[i].count, directed[i].typed, directed[i].want);
			end
		end

		// Random part: one setting per phase, write-heavy phases to reach full and overwrite.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin ph_cap = 7'd3;   ph_drop = 1'b0; ph_items = 30; ph_wr_pct = 60; end
				1: begin ph_cap = 7'd64;  ph_drop = 1'b1; ph_items = 80; ph_wr_pct = 92; end
				2: begin ph_cap = 7'd2;   ph_drop = 1'b1; ph_items = 25; ph_wr_pct = 70; end
				3: begin ph_cap = 7'd0;   ph_drop = 1'b0; ph_items = 20; ph_wr_pct = 55; end
				4: begin ph_cap = 7'd17;  ph_drop = 1'b1; ph_items = 30; ph_wr_pct = 70; end
				5: begin ph_cap = 7'd127; ph_drop = 1'b0; ph_items = 30; ph_wr_pct = 50; end
				6: begin ph_cap = 7'd1;   ph_drop = 1'b1; ph_items = 20; ph_wr_pct = 65; end
				default: begin
					ph_cap    = CFG_DATA_W'($urandom_range(2, 64));
					ph_drop   = $urandom_range(0, 1);
					ph_items  = 35;
					ph_wr_pct = 75;
				end
			endcase
			write_reg(REG_CAPACITY, ph_cap);
			// upper data bits are don't-care for the drop-oldest flag
			write_reg(REG_DROP_OLDEST, {CFG_DATA_W'($urandom_range(0, 63)) << 1} | ph_drop);
			for (int k = 0; k < ph_items; k++) begin
				if (ph == 1 && k == 40) settle();
				ph_mode = ($urandom_range(0, 99) >= ph_wr_pct) ? MODE_READ : MODE_WRITE;
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					ph_cnt = '0;
				end else if (pick == 1) begin
					ph_cnt = cnt_t'(MAX_BURST);
				end else if (pick == 2) begin
					ph_cnt = cnt_t'(mirror_level);
				end else begin
					ph_cnt = cnt_t'($urandom_range(1, 6));
				end
				send_item(ph_mode, {$urandom, $urandom}, ph_cnt, 1'b0, '0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("Run covered %0d writes (%0d into a full FIFO) and %0d reads, %0d beats checked",
			writes_sent, full_writes, reads_sent, beats_checked);
		$display("Capacity written %0d times, longest burst %0d samples",
			cap_settings, longest_burst);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
